@@ rtl/assert_macros.svh @@
// Assertion macros shared by the packer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define LBFP_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("invariant violated");

// Consequence that must hold at the clock edge after the antecedent.
`define LBFP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle property violated");

`endif

@@ rtl/lbfp_pkg.sv @@
// Shared types and constants for the LSB-first bit-field packer.
// No dependencies; imported by every packer module.
package lbfp_pkg;

    localparam int unsigned MAX_MESSAGE_BYTES = 16384;
    // Byte counter and capacity register width; must hold MAX_MESSAGE_BYTES itself.
    localparam int unsigned COUNT_W   = 15;
    localparam int unsigned INDEX_W   = 14;
    localparam int unsigned BITCAP_W  = COUNT_W + 3;
    localparam int unsigned BURST_MAX = 4;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] CAP_LIMIT = COUNT_W'(MAX_MESSAGE_BYTES);

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_OVERFLOW = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] field_value;
        logic [5:0]  num_bits;
        logic        signed_field;
    } request_t;

    typedef struct packed {
        logic [COUNT_W-1:0] bytes_used;
        logic [2:0]         bit_position;
        logic [7:0]         partial_byte;
        logic               overflow_seen;
    } msg_state_t;

    // Everything one request produces: up to four bytes, sent in order.
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [INDEX_W-1:0]        first_index;
        logic [2:0]                count;
        logic                      byte_valid;
        logic                      range_warning;
        logic                      restarted;
        logic                      error_flag;
    } burst_t;

endpackage

@@ rtl/lbfp_pack.sv @@
// Single-pass packing logic: range check, capacity check and byte merge.
// Depends on lbfp_pkg.
module lbfp_pack
    import lbfp_pkg::*;
(
    input  request_t           req,
    input  msg_state_t         cur,
    input  logic [COUNT_W-1:0] max_bytes,
    input  logic               allow_overflow,
    output msg_state_t         nxt,
    output burst_t             burst
);

    logic                bad_width;
    logic                warn;
    logic                overflow;
    logic [31:0]         field_mask;
    logic [31:0]         top_bits;
    logic [7:0]          part_mask;
    logic [39:0]         merged;
    logic [5:0]          total_bits;
    logic [2:0]          done_bytes;
    logic [COUNT_W-1:0]  cap;
    logic [COUNT_W-1:0]  base_count;
    logic [BITCAP_W-1:0] cap_bits;
    logic [BITCAP_W-1:0] written;
    logic [BITCAP_W:0]   need;

    assign bad_width  = (req.num_bits == 6'd0) || (req.num_bits > 6'd32)
                        || (req.signed_field && (req.num_bits == 6'd32));
    assign field_mask = 32'hFFFF_FFFF >> (6'd32 - req.num_bits);
    assign top_bits   = req.field_value >> (req.num_bits - 6'd1);

    always_comb begin
        if (bad_width) begin
            warn = 1'b0;
        end else if (req.signed_field) begin
            warn = !((top_bits == 32'd0)
                     || (top_bits == (32'hFFFF_FFFF >> (req.num_bits - 6'd1))));
        end else if (req.num_bits == 6'd32) begin
            warn = 1'b0;
        end else begin
            warn = (req.field_value >> req.num_bits) != 32'd0;
        end
    end

    // Capacity in bits against bits already written plus this field.
    assign cap      = (max_bytes > CAP_LIMIT) ? CAP_LIMIT : max_bytes;
    assign cap_bits = {cap, 3'b000};
    assign written  = {cur.bytes_used, 3'b000}
                      - BITCAP_W'((4'd8 - {1'b0, cur.bit_position}) & 4'h7);
    assign need     = {1'b0, written} + (BITCAP_W + 1)'(req.num_bits);
    assign overflow = need > {1'b0, cap_bits};

    // Old partial bits below, new field bits above them.
    assign part_mask  = 8'hFF >> (4'd8 - {1'b0, cur.bit_position});
    assign merged     = {32'd0, cur.partial_byte & part_mask}
                        | ({8'd0, req.field_value & field_mask} << cur.bit_position);
    assign total_bits = {3'b000, cur.bit_position} + req.num_bits;
    assign done_bytes = total_bits[5:3];
    assign base_count = (cur.bit_position == 3'd0) ? cur.bytes_used
                                                   : cur.bytes_used - COUNT_W'(1);

    always_comb begin
        nxt   = cur;
        burst = '0;
        burst.count = 3'd1;
        if (req.cmd == CMD_FLUSH) begin
            burst.restarted = cur.overflow_seen;
            if (cur.bit_position != 3'd0) begin
                burst.bytes[0]    = cur.partial_byte & part_mask;
                burst.first_index = INDEX_W'(cur.bytes_used - COUNT_W'(1));
                burst.byte_valid  = 1'b1;
            end
            nxt = '0;
        end else if (bad_width) begin
            burst.error_flag = 1'b1;
        end else if (overflow) begin
            burst.range_warning = warn;
            if (!allow_overflow || (BITCAP_W'(req.num_bits) > cap_bits)) begin
                burst.error_flag = 1'b1;
            end else begin
                burst.restarted   = 1'b1;
                nxt               = '0;
                nxt.overflow_seen = 1'b1;
            end
        end else begin
            burst.range_warning = warn;
            nxt.bytes_used   = base_count + COUNT_W'((total_bits + 6'd7) >> 3);
            nxt.bit_position = total_bits[2:0];
            nxt.partial_byte = merged[{done_bytes, 3'b000} +: 8];
            if (done_bytes != 3'd0) begin
                burst.bytes       = merged[31:0];
                burst.first_index = INDEX_W'(base_count);
                burst.count       = done_bytes;
                burst.byte_valid  = 1'b1;
            end
        end
    end

endmodule

@@ rtl/lbfp_burst.sv @@
// Result register that sends the one to four items of a request, one per beat.
// Depends on lbfp_pkg.
module lbfp_burst
    import lbfp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  burst_t             load_data,
    output logic               can_load,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_byte_value,
    output logic [INDEX_W-1:0] m_byte_index,
    output logic               m_byte_valid,
    output logic               m_last,
    output logic               m_range_warning,
    output logic               m_restarted,
    output logic               m_error_flag
);

    logic                      busy_reg;
    logic                      busy_next;
    logic [2:0]                left_reg;
    logic [2:0]                left_next;
    logic [BURST_MAX-1:0][7:0] bytes_reg;
    logic [INDEX_W-1:0]        index_reg;
    logic                      byte_valid_reg;
    logic                      warn_reg;
    logic                      restarted_reg;
    logic                      error_reg;
    logic                      beat;

    assign beat     = busy_reg && m_ready;
    assign can_load = !busy_reg || (m_ready && (left_reg == 3'd1));

    always_comb begin
        busy_next = busy_reg;
        left_next = left_reg;
        if (load) begin
            busy_next = 1'b1;
            left_next = load_data.count;
        end else if (beat) begin
            left_next = left_reg - 3'd1;
            if (left_reg == 3'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            left_reg <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg      <= load_data.bytes;
            index_reg      <= load_data.first_index;
            byte_valid_reg <= load_data.byte_valid;
            warn_reg       <= load_data.range_warning;
            restarted_reg  <= load_data.restarted;
            error_reg      <= load_data.error_flag;
        end else if (beat) begin
            bytes_reg <= {8'd0, bytes_reg[BURST_MAX-1:1]};
            index_reg <= index_reg + INDEX_W'(1);
        end
    end

    assign m_valid         = busy_reg;
    assign m_byte_value    = bytes_reg[0];
    assign m_byte_index    = index_reg;
    assign m_byte_valid    = byte_valid_reg;
    assign m_last          = (left_reg == 3'd1);
    assign m_range_warning = warn_reg;
    assign m_restarted     = restarted_reg;
    assign m_error_flag    = error_reg;

endmodule

@@ rtl/lsb_first_bit_field_packer_top.sv @@
// LSB-first bit-field packer, top level; uses lbfp_pkg, lbfp_pack, lbfp_burst.
// A request waits in the input register until the result register can take it;
// its first result is then offered from the result register. Throughput: one request
// per cycle while m_ready is high and each yields a single result (results run 1 to 4).
// Reset (aresetn low, synchronous) empties the message and both registers, and sets
// max_bytes to 16384 and allow_overflow to 0.
`include "assert_macros.svh"

module lsb_first_bit_field_packer_top
    import lbfp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]   cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [31:0]          s_field_value,
    input  logic [5:0]           s_num_bits,
    input  logic                 s_signed_field,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_byte_value,
    output logic [INDEX_W-1:0]   m_byte_index,
    output logic                 m_byte_valid,
    output logic                 m_last,
    output logic                 m_range_warning,
    output logic                 m_restarted,
    output logic                 m_error_flag
);

    // Configuration registers. The user must see that they are only written while the block is idle,
    // so no request in flight ever sees a change halfway through; the block itself does not enforce it.
    logic [COUNT_W-1:0] max_bytes_reg;
    logic               allow_overflow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg      <= CAP_LIMIT;
            allow_overflow_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAX_BYTES:      max_bytes_reg      <= cfg_wdata;
                CFG_ALLOW_OVERFLOW: allow_overflow_reg <= cfg_wdata[0];
                default:            ;
            endcase
        end
    end

    // Input register. A request waits here until the result register can take
    // everything it produces; the message state advances at that same edge, so
    // requests are packed strictly in arrival order.
    request_t   req_reg;
    logic       req_full_reg;
    logic       req_full_next;
    msg_state_t state_reg;
    msg_state_t state_next;
    burst_t     burst;
    logic       can_load;
    logic       load_fire;
    logic       s_fire;

    assign load_fire = req_full_reg && can_load;
    // The register frees up in the same cycle its request moves on, so a new
    // request can be taken then; while a held request waits, s_ready stays low.
    assign s_ready   = !req_full_reg || can_load;
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        req_full_next = req_full_reg;
        if (s_fire) begin
            req_full_next = 1'b1;
        end else if (load_fire) begin
            req_full_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_full_reg <= 1'b0;
            state_reg    <= '0;
        end else begin
            req_full_reg <= req_full_next;
            if (load_fire) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg.cmd          <= s_cmd;
            req_reg.field_value  <= s_field_value;
            req_reg.num_bits     <= s_num_bits;
            req_reg.signed_field <= s_signed_field;
        end
    end

    // Range check, capacity check and the merge of the field into the byte
    // stream, all in one pass between the input and result registers.
    lbfp_pack u_pack (
        .req            (req_reg),
        .cur            (state_reg),
        .max_bytes      (max_bytes_reg),
        .allow_overflow (allow_overflow_reg),
        .nxt            (state_next),
        .burst          (burst)
    );

    // Result register: holds the finished bytes of one request and hands them
    // out one per accepted beat, with last on the final one.
    lbfp_burst u_burst (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (load_fire),
        .load_data       (burst),
        .can_load        (can_load),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_value    (m_byte_value),
        .m_byte_index    (m_byte_index),
        .m_byte_valid    (m_byte_valid),
        .m_last          (m_last),
        .m_range_warning (m_range_warning),
        .m_restarted     (m_restarted),
        .m_error_flag    (m_error_flag)
    );

    // A status-only result is always the single result of its request.
    `LBFP_ASSERT_ALWAYS(a_status_is_last, aclk, aresetn, !m_valid || m_byte_valid || m_last)
    // Within one request the bytes follow at consecutive indexes without a gap.
    `LBFP_ASSERT_NEXT(a_burst_index_step, aclk, aresetn, m_valid && m_ready && !m_last, m_valid && m_byte_valid && (m_byte_index == $past(m_byte_index) + 14'd1))
    // A refused field never also reports a restart.
    `LBFP_ASSERT_ALWAYS(a_flags_exclusive, aclk, aresetn, !(m_valid && m_error_flag && m_restarted))
    // The byte count never passes the largest message the block supports.
    `LBFP_ASSERT_ALWAYS(a_count_in_range, aclk, aresetn, state_reg.bytes_used <= CAP_LIMIT)

endmodule
